@@ rtl/scc_pkg.sv @@
// shared types, constants and calendar functions of the scaled calendar clock
`default_nettype none

package scc_pkg;

  // field widths
  localparam int DELTA_W = 10;
  localparam int MULT_W  = 17;
  localparam int PROD_W  = DELTA_W + MULT_W;
  localparam int QUO_W   = 18;
  localparam int YEAR_W  = 14;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;
  localparam int WDAY_W  = 3;
  localparam int HOUR_W  = 5;
  localparam int MIN_W   = 6;
  localparam int SEC_W   = 6;
  localparam int MS_W    = 10;

  // stream widths
  localparam int IN_DATA_W  = 64;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 48;

  // fixed values
  localparam logic [YEAR_W-1:0] YEAR_LIMIT    = 14'd9999;
  localparam logic [MULT_W-1:0] MULT_RESET    = 17'd1;
  localparam logic [WDAY_W-1:0] RESET_WEEKDAY = 3'd6;

  typedef enum logic [1:0] {
    ACT_TICK     = 2'd0,
    ACT_SET_DATE = 2'd1,
    ACT_SET_TIME = 2'd2
  } action_e;

  typedef struct packed {
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
    logic [WDAY_W-1:0]  weekday;
  } date_t;

  typedef struct packed {
    logic [HOUR_W-1:0] hour;
    logic [MIN_W-1:0]  minute;
    logic [SEC_W-1:0]  second;
    logic [MS_W-1:0]   milli;
  } tod_t;

  // one item as it moves down the preparation pipeline
  typedef struct packed {
    action_e             action;
    logic [DELTA_W-1:0]  delta_ms;
    date_t               date;      // set-date fields, clamped on the way
    tod_t                tod;       // set-time fields, clamped on the way
    logic [PROD_W-1:0]   num;       // dividend of the current split step
    logic [QUO_W-1:0]    quo;       // quotient estimate of the current split step
    logic                span_day;  // whole day carried by the scaled delta
    tod_t                span;      // scaled delta as time of day
    logic [14:0]         w_yy;      // shifted year for the weekday formula
    logic [8:0]          w_cen;     // centuries of w_yy
    logic [15:0]         w_sum;     // weekday sum before mod 7
    logic [13:0]         w_quo;     // w_sum / 7 estimate
  } work_t;

  // leap year test: divisible by 4 and, if a century, by 400
  function automatic logic is_leap(logic [YEAR_W-1:0] y);
    logic [YEAR_W-3:0] t;
    logic [YEAR_W-3:0] p;
    logic              div25;
    t     = y[YEAR_W-1:2];
    // multiply by the inverse of 25 modulo 2^12: a multiple of 25 lands low
    p     = t * 12'd3113;
    div25 = (p <= 12'd163);
    return (y[1:0] == 2'b00) && (!div25 || (y[3:0] == 4'b0000));
  endfunction

  function automatic logic [DAY_W-1:0] days_in(logic [YEAR_W-1:0] y, logic [MONTH_W-1:0] m);
    logic [DAY_W-1:0] d;
    case (m) inside
      4'd2:                   d = is_leap(y) ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11: d = 5'd30;
      default:                d = 5'd31;
    endcase
    return d;
  endfunction

  function automatic logic [2:0] month_offset(logic [MONTH_W-1:0] m);
    logic [2:0] o;
    case (m)
      4'd2:    o = 3'd3;
      4'd3:    o = 3'd2;
      4'd4:    o = 3'd5;
      4'd6:    o = 3'd3;
      4'd7:    o = 3'd5;
      4'd8:    o = 3'd1;
      4'd9:    o = 3'd4;
      4'd10:   o = 3'd6;
      4'd11:   o = 3'd2;
      4'd12:   o = 3'd4;
      default: o = 3'd0;
    endcase
    return o;
  endfunction

  // one calendar day forward, year held at its limit
  function automatic date_t next_day(date_t d);
    date_t n;
    n = d;
    n.weekday = (d.weekday >= 3'd7) ? 3'd1 : d.weekday + 3'd1;
    if (d.day >= days_in(d.year, d.month)) begin
      n.day = 5'd1;
      if (d.month >= 4'd12) begin
        n.month = 4'd1;
        if (d.year < YEAR_LIMIT) begin
          n.year = d.year + 14'd1;
        end
      end else begin
        n.month = d.month + 4'd1;
      end
    end else begin
      n.day = d.day + 5'd1;
    end
    return n;
  endfunction

endpackage

`default_nettype wire

@@ rtl/scc_prep.sv @@
// preparation pipeline: splits the scaled delta and clamps set fields, weekday of set date
`default_nettype none

module scc_prep (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic [scc_pkg::MULT_W-1:0] mult_i,
  input  wire logic                       in_valid_i,
  output logic                            in_ready_o,
  input  wire scc_pkg::work_t             in_work_i,
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output scc_pkg::work_t                  out_work_o
);
  import scc_pkg::*;

  localparam int NumStages = 8;

  // reciprocals, each floor(2^k / divisor) for a k-bit dividend
  localparam logic [17:0] RecipMs  = 18'd134217;  // 2^24 / 125
  localparam logic [12:0] RecipSec = 13'd4369;    // 2^18 / 60
  localparam logic [6:0]  RecipMin = 7'd68;       // 2^12 / 60
  localparam logic [8:0]  RecipCen = 9'd327;      // 2^15 / 100
  localparam logic [13:0] RecipWd  = 14'd9362;    // 2^16 / 7

  logic [NumStages-1:0] v_q;
  logic [NumStages-1:0] v_d;
  logic [NumStages:0]   rdy;
  work_t                st_q [NumStages];
  work_t                st_d [NumStages];

  // work done between stage register k and k+1
  function automatic work_t stage_fn(int k, work_t s, logic [MULT_W-1:0] mult);
    work_t        n;
    logic [41:0]  p1;
    logic [27:0]  r1;
    logic [30:0]  p2;
    logic [17:0]  r2;
    logic [18:0]  p3;
    logic [11:0]  r3;
    logic [5:0]   hrs;
    logic [23:0]  pc;
    logic [14:0]  rc;
    logic [29:0]  pw;
    logic [15:0]  rw;
    logic [4:0]   dmax;
    n = s;
    case (k)
      0: begin
        // scaled delta in ms, clamps of year, month and time fields
        n.num = PROD_W'(s.delta_ms) * PROD_W'(mult);
        if (s.date.year > YEAR_LIMIT) n.date.year = YEAR_LIMIT;
        if (s.date.month == 4'd0) n.date.month = 4'd1;
        else if (s.date.month > 4'd12) n.date.month = 4'd12;
        if (s.tod.hour > 5'd23) n.tod.hour = 5'd23;
        if (s.tod.minute > 6'd59) n.tod.minute = 6'd59;
        if (s.tod.second > 6'd59) n.tod.second = 6'd59;
        if (s.tod.milli > 10'd999) n.tod.milli = 10'd999;
      end
      1: begin
        // ms / 1000 as (ms / 8) / 125, estimate low by at most one
        p1    = 42'(s.num[PROD_W-1:3]) * 42'(RecipMs);
        n.quo = p1[41:24];
        dmax  = days_in(s.date.year, s.date.month);
        if (s.date.day == 5'd0) n.date.day = 5'd1;
        else if (s.date.day > dmax) n.date.day = dmax;
        n.w_yy = 15'(s.date.year) + 15'd400 - ((s.date.month <= 4'd2) ? 15'd1 : 15'd0);
      end
      2: begin
        r1 = {1'b0, s.num} - 28'(s.quo) * 28'd1000;
        if (r1 >= 28'd1000) begin
          n.span.milli = 10'(r1 - 28'd1000);
          n.num        = PROD_W'(s.quo) + PROD_W'(1);
        end else begin
          n.span.milli = 10'(r1);
          n.num        = PROD_W'(s.quo);
        end
        pc      = 24'(s.w_yy) * 24'(RecipCen);
        n.w_cen = pc[23:15];
      end
      3: begin
        // seconds / 60
        p2    = 31'(s.num[17:0]) * 31'(RecipSec);
        n.quo = QUO_W'(p2[30:18]);
        rc    = s.w_yy - 15'(s.w_cen) * 15'd100;
        if (rc >= 15'd100) n.w_cen = s.w_cen + 9'd1;
      end
      4: begin
        r2 = s.num[17:0] - 18'(s.quo) * 18'd60;
        if (r2 >= 18'd60) begin
          n.span.second = 6'(r2 - 18'd60);
          n.num         = PROD_W'(s.quo) + PROD_W'(1);
        end else begin
          n.span.second = 6'(r2);
          n.num         = PROD_W'(s.quo);
        end
        n.w_sum = 16'(s.w_yy) + 16'(s.w_yy[14:2]) - 16'(s.w_cen) + 16'(s.w_cen[8:2])
                + 16'(month_offset(s.date.month)) + 16'(s.date.day);
      end
      5: begin
        // minutes / 60
        p3      = 19'(s.num[11:0]) * 19'(RecipMin);
        n.quo   = QUO_W'(p3[18:12]);
        pw      = 30'(s.w_sum) * 30'(RecipWd);
        n.w_quo = pw[29:16];
      end
      6: begin
        r3 = s.num[11:0] - 12'(s.quo) * 12'd60;
        if (r3 >= 12'd60) begin
          n.span.minute = 6'(r3 - 12'd60);
          hrs           = 6'(s.quo) + 6'd1;
        end else begin
          n.span.minute = 6'(r3);
          hrs           = 6'(s.quo);
        end
        n.span_day  = (hrs >= 6'd24);
        n.span.hour = n.span_day ? 5'(hrs - 6'd24) : 5'(hrs);
        rw = s.w_sum - 16'(s.w_quo) * 16'd7;
        if (rw >= 16'd7) rw = rw - 16'd7;
        n.date.weekday = (rw == 16'd0) ? 3'd7 : 3'(rw);
      end
      default: n = s;
    endcase
    return n;
  endfunction

  // a stage loads when it is empty or its successor moves on
  always_comb begin
    rdy[NumStages] = out_ready_i;
    for (int k = NumStages - 1; k >= 0; k--) begin
      rdy[k] = !v_q[k] || rdy[k+1];
    end
  end

  // next stage contents
  always_comb begin
    v_d[0]  = in_valid_i;
    st_d[0] = in_work_i;
    for (int k = 1; k < NumStages; k++) begin
      v_d[k]  = v_q[k-1];
      st_d[k] = stage_fn(k - 1, st_q[k-1], mult_i);
    end
  end

  // stage valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 0; k < NumStages; k++) begin
        if (rdy[k]) v_q[k] <= v_d[k];
      end
    end
  end

  // stage payload
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NumStages; k++) begin
      if (rdy[k]) st_q[k] <= st_d[k];
    end
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = v_q[NumStages-1];
  assign out_work_o  = st_q[NumStages-1];

endmodule

`default_nettype wire

@@ rtl/scc_calendar.sv @@
// calendar state: adds the split delta with carries, loads set values, holds the result
`default_nettype none

module scc_calendar (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  wire scc_pkg::work_t in_work_i,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output scc_pkg::date_t      out_date_o,
  output scc_pkg::tod_t       out_tod_o
);
  import scc_pkg::*;

  date_t       date_q;
  date_t       date_d;
  tod_t        tod_q;
  tod_t        tod_d;
  logic        out_valid_q;
  logic        take;

  logic [10:0] ms_sum;
  logic [6:0]  sec_sum;
  logic [6:0]  min_sum;
  logic [5:0]  hour_sum;
  logic        c_ms;
  logic        c_sec;
  logic        c_min;
  logic        c_hour;
  logic [1:0]  day_cnt;
  tod_t        tod_tick;
  date_t       day1;
  date_t       day2;
  date_t       date_tick;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign take       = in_valid_i && in_ready_o;

  // mixed-radix add of the delta to the time of day
  always_comb begin
    ms_sum  = 11'(tod_q.milli) + 11'(in_work_i.span.milli);
    c_ms    = (ms_sum >= 11'd1000);
    tod_tick.milli = c_ms ? 10'(ms_sum - 11'd1000) : ms_sum[9:0];
    sec_sum = 7'(tod_q.second) + 7'(in_work_i.span.second) + 7'(c_ms);
    c_sec   = (sec_sum >= 7'd60);
    tod_tick.second = c_sec ? 6'(sec_sum - 7'd60) : sec_sum[5:0];
    min_sum = 7'(tod_q.minute) + 7'(in_work_i.span.minute) + 7'(c_sec);
    c_min   = (min_sum >= 7'd60);
    tod_tick.minute = c_min ? 6'(min_sum - 7'd60) : min_sum[5:0];
    hour_sum = 6'(tod_q.hour) + 6'(in_work_i.span.hour) + 6'(c_min);
    c_hour   = (hour_sum >= 6'd24);
    tod_tick.hour = c_hour ? 5'(hour_sum - 6'd24) : hour_sum[4:0];
    day_cnt = 2'(in_work_i.span_day) + 2'(c_hour);
  end

  // at most two days carried by one tick
  always_comb begin
    day1 = next_day(date_q);
    day2 = next_day(day1);
    case (day_cnt)
      2'd0:    date_tick = date_q;
      2'd1:    date_tick = day1;
      default: date_tick = day2;
    endcase
  end

  // next state by action
  always_comb begin
    date_d = date_q;
    tod_d  = tod_q;
    unique case (in_work_i.action)
      ACT_TICK: begin
        date_d = date_tick;
        tod_d  = tod_tick;
      end
      ACT_SET_DATE: date_d = in_work_i.date;
      ACT_SET_TIME: tod_d  = in_work_i.tod;
      default: begin
        date_d = date_q;
        tod_d  = tod_q;
      end
    endcase
  end

  // state doubles as the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      date_q      <= '{year: '0, month: 4'd1, day: 5'd1, weekday: RESET_WEEKDAY};
      tod_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (take) begin
        date_q      <= date_d;
        tod_q       <= tod_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_date_o  = date_q;
  assign out_tod_o   = tod_q;

endmodule

`default_nettype wire

@@ rtl/scaled_calendar_clock.sv @@
// top level of the scaled calendar clock
//
// Gregorian date and time of day advanced by scaled ticks.
// Input stream (s_axis): one transaction per item, tuser carries the action
// (tick, set date, set time), tdata the tick delta and the set values.
// Output stream (m_axis): one transaction per input item with the date and
// time after that item took effect, in input order.
// Configuration channel (cfg_*): writes time_mult, the game milliseconds per
// real millisecond; cfg_ready_o is always high. Write it only while idle.
// Path: an input transaction passes through the eight-stage preparation
// pipeline (delta multiply, three reciprocal divides by 1000, 60 and 60,
// date clamps and weekday) into the calendar register, which drives m_axis.
// Throughput: one item per cycle while m_axis_tready takes results; the
// calendar update, including up to two day carries, is combinational.
// Reset: Jan 1 of year 0 (a Saturday), 00:00:00.000, time_mult 1, pipeline
// empty. A stalled receiver holds the result; the pipeline keeps accepting
// until its eight stages are full, then s_axis_tready drops.
`default_nettype none

module scaled_calendar_clock (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // configuration write
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [scc_pkg::MULT_W-1:0]    cfg_data_i,     // time_mult
  // input items
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  // delta_ms, set_year, set_month, set_day, set_hour, set_minute, set_second,
  // set_millisecond, zero pad
  input  wire logic [scc_pkg::IN_DATA_W-1:0] s_axis_tdata,
  input  wire logic [scc_pkg::IN_USER_W-1:0] s_axis_tuser,   // action
  // results
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  // year, month, day, weekday, hour, minute, second, zero pad
  output logic [scc_pkg::OUT_DATA_W-1:0]     m_axis_tdata
);
  import scc_pkg::*;

  logic [MULT_W-1:0] time_mult_q;
  work_t             in_work;
  work_t             prep_work;
  logic              prep_valid;
  logic              prep_ready;
  date_t             out_date;
  tod_t              out_tod;

  // multiplier register
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_mult_q <= MULT_RESET;
    end else if (cfg_valid_i) begin
      time_mult_q <= cfg_data_i;
    end
  end

  // unpack the input transaction
  always_comb begin
    in_work              = '0;
    in_work.action       = action_e'(s_axis_tuser);
    in_work.delta_ms     = s_axis_tdata[9:0];
    in_work.date.year    = s_axis_tdata[23:10];
    in_work.date.month   = s_axis_tdata[27:24];
    in_work.date.day     = s_axis_tdata[32:28];
    in_work.tod.hour     = s_axis_tdata[37:33];
    in_work.tod.minute   = s_axis_tdata[43:38];
    in_work.tod.second   = s_axis_tdata[49:44];
    in_work.tod.milli    = s_axis_tdata[59:50];
  end

  scc_prep u_prep (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .mult_i      (time_mult_q),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_work_i   (in_work),
    .out_valid_o (prep_valid),
    .out_ready_i (prep_ready),
    .out_work_o  (prep_work)
  );

  scc_calendar u_calendar (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (prep_valid),
    .in_ready_o  (prep_ready),
    .in_work_i   (prep_work),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_date_o  (out_date),
    .out_tod_o   (out_tod)
  );

  // pack the result
  assign m_axis_tdata = {5'b0, out_tod.second, out_tod.minute, out_tod.hour,
                         out_date.weekday, out_date.day, out_date.month, out_date.year};

endmodule

`default_nettype wire

@@ rtl/scc_checker.sv @@
// port-level checker of the scaled calendar clock and its bind
`default_nettype none

module scc_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        cfg_valid_i,
  input wire logic        cfg_ready_o,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [47:0] m_axis_tdata
);

  logic [3:0] pending_q;
  logic       in_xfer;
  logic       out_xfer;

  assign in_xfer  = s_axis_tvalid && s_axis_tready;
  assign out_xfer = m_axis_tvalid && m_axis_tready;

  // items accepted but not yet delivered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else begin
      pending_q <= pending_q + 4'(in_xfer) - 4'(out_xfer);
    end
  end

  // a result only exists for an accepted item
  a_result_has_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (pending_q != 4'd0))
    else $error("result shown with no item outstanding");

  // every calendar field of a result is in range
  a_fields_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[13:0] <= 14'd9999)
      && (m_axis_tdata[17:14] >= 4'd1) && (m_axis_tdata[17:14] <= 4'd12)
      && (m_axis_tdata[22:18] >= 5'd1) && (m_axis_tdata[22:18] <= 5'd31)
      && (m_axis_tdata[25:23] >= 3'd1) && (m_axis_tdata[25:23] <= 3'd7)
      && (m_axis_tdata[30:26] <= 5'd23) && (m_axis_tdata[36:31] <= 6'd59)
      && (m_axis_tdata[42:37] <= 6'd59))
    else $error("result field out of range");

  // the clock only moves when a new result can be loaded
  a_state_moves_on_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(m_axis_tdata) |-> $past(!m_axis_tvalid || m_axis_tready))
    else $error("date or time changed while a result was waiting");

  // a stalled result holds
  a_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result dropped or changed");

  // the multiplier is only written with nothing in flight
  a_cfg_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i && cfg_ready_o |-> (pending_q == 4'd0))
    else $error("configuration written with items in flight");

endmodule

bind scaled_calendar_clock scc_checker u_scc_checker (.*);

`default_nettype wire

@@ verif/tb.sv @@
`timescale 1ns / 1ps
// testbench for scaled_calendar_clock: directed table, then random phases checked by a calendar predictor

module tb;
  import scc_pkg::*;

  localparam logic [1:0] ACT_NONE = 2'd3;   // unused action, returns the current stamp only
  localparam int CYCLE_LIMIT  = 400000;
  localparam int NUM_PHASES   = 8;
  localparam int PHASE_ITEMS  = 190;
  localparam int DRAIN_CYCLES = 16;
  localparam int MAX_REPORTS  = 10;

  // one input item, action on top
  typedef struct packed {
    logic [1:0]         action;
    logic [MS_W-1:0]    set_millisecond;
    logic [SEC_W-1:0]   set_second;
    logic [MIN_W-1:0]   set_minute;
    logic [HOUR_W-1:0]  set_hour;
    logic [DAY_W-1:0]   set_day;
    logic [MONTH_W-1:0] set_month;
    logic [YEAR_W-1:0]  set_year;
    logic [DELTA_W-1:0] delta_ms;
  } clock_cmd_t;

  // one result, year in the lowest bits as on m_axis_tdata
  typedef struct packed {
    logic [SEC_W-1:0]   second;
    logic [MIN_W-1:0]   minute;
    logic [HOUR_W-1:0]  hour;
    logic [WDAY_W-1:0]  weekday;
    logic [DAY_W-1:0]   day;
    logic [MONTH_W-1:0] month;
    logic [YEAR_W-1:0]  year;
  } stamp_t;

  typedef struct packed {
    logic              wr_rate;
    logic [MULT_W-1:0] rate;
    clock_cmd_t        cmd;
    logic              typed;
    stamp_t            want;
  } dir_row_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [MULT_W-1:0]     cfg_data_i = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic [IN_USER_W-1:0]  s_axis_tuser = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;

  // predictor state
  logic [MULT_W-1:0]  game_rate;
  logic [YEAR_W-1:0]  cal_year;
  logic [MONTH_W-1:0] cal_month;
  logic [DAY_W-1:0]   cal_day;
  logic [WDAY_W-1:0]  cal_wday;
  logic [HOUR_W-1:0]  cal_hour;
  logic [MIN_W-1:0]   cal_min;
  logic [SEC_W-1:0]   cal_sec;
  logic [MS_W-1:0]    cal_ms;

  stamp_t   stamp_q[$];
  dir_row_t directed_rows[$];
  int       fail_count = 0;
  int       cycle_count = 0;
  int       send_idle_pct = 0;
  int       recv_stall_pct = 0;

  scaled_calendar_clock dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // 12 ns clock
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // calendar arithmetic
  function automatic bit leap_year(int y);
    return ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
  endfunction

  function automatic int month_days(int y, int m);
    int d;
    case (m)
      2:             d = leap_year(y) ? 29 : 28;
      4, 6, 9, 11:   d = 30;
      default:       d = 31;
    endcase
    return d;
  endfunction

  // day of week 1 monday .. 7 sunday, year shifted by a full 400-year cycle
  function automatic int weekday_for(int y, int m, int d);
    int shift;
    int yy;
    int s;
    case (m)
      2, 6:    shift = 3;
      3, 11:   shift = 2;
      4, 7:    shift = 5;
      8:       shift = 1;
      9, 12:   shift = 4;
      10:      shift = 6;
      default: shift = 0;
    endcase
    yy = y + 400 - ((m < 3) ? 1 : 0);
    s  = (yy + yy / 4 - yy / 100 + yy / 400 + shift + d) % 7;
    return (s == 0) ? 7 : s;
  endfunction

  function automatic void calendar_reset();
    game_rate = MULT_W'(1);
    cal_year  = '0;
    cal_month = MONTH_W'(1);
    cal_day   = DAY_W'(1);
    cal_wday  = WDAY_W'(weekday_for(0, 1, 1));
    cal_hour  = '0;
    cal_min   = '0;
    cal_sec   = '0;
    cal_ms    = '0;
  endfunction

  // one day forward, year held at its cap
  function automatic void roll_one_day();
    cal_wday = (cal_wday >= 3'd7) ? WDAY_W'(1) : cal_wday + WDAY_W'(1);
    if (int'(cal_day) >= month_days(cal_year, cal_month)) begin
      cal_day = DAY_W'(1);
      if (cal_month >= 4'd12) begin
        cal_month = MONTH_W'(1);
        if (cal_year < YEAR_LIMIT) cal_year = cal_year + YEAR_W'(1);
      end else begin
        cal_month = cal_month + MONTH_W'(1);
      end
    end else begin
      cal_day = cal_day + DAY_W'(1);
    end
  endfunction

  // apply one item to the predictor and return the stamp it yields
  function automatic stamp_t calendar_step(clock_cmd_t c);
    longint unsigned msum;
    longint unsigned ssum;
    longint unsigned mnsum;
    longint unsigned hsum;
    longint unsigned days;
    int              mo;
    int              dmax;
    stamp_t          s;
    if (c.action == ACT_TICK) begin
      msum  = longint'(cal_ms) + longint'(c.delta_ms) * longint'(game_rate);
      ssum  = longint'(cal_sec) + msum / 1000;
      mnsum = longint'(cal_min) + ssum / 60;
      hsum  = longint'(cal_hour) + mnsum / 60;
      days  = hsum / 24;
      cal_ms   = MS_W'(msum % 1000);
      cal_sec  = SEC_W'(ssum % 60);
      cal_min  = MIN_W'(mnsum % 60);
      cal_hour = HOUR_W'(hsum % 24);
      while (days > 0) begin
        roll_one_day();
        days--;
      end
    end else if (c.action == ACT_SET_DATE) begin
      cal_year  = (c.set_year > YEAR_LIMIT) ? YEAR_LIMIT : c.set_year;
      mo        = (c.set_month < 1) ? 1 : (c.set_month > 12) ? 12 : int'(c.set_month);
      cal_month = MONTH_W'(mo);
      dmax      = month_days(cal_year, mo);
      cal_day   = DAY_W'((c.set_day < 1) ? 1 : (c.set_day > dmax) ? dmax : int'(c.set_day));
      cal_wday  = WDAY_W'(weekday_for(cal_year, cal_month, cal_day));
    end else if (c.action == ACT_SET_TIME) begin
      cal_hour = (c.set_hour > 23) ? HOUR_W'(23) : c.set_hour;
      cal_min  = (c.set_minute > 59) ? MIN_W'(59) : c.set_minute;
      cal_sec  = (c.set_second > 59) ? SEC_W'(59) : c.set_second;
      cal_ms   = (c.set_millisecond > 999) ? MS_W'(999) : c.set_millisecond;
    end
    s.year    = cal_year;
    s.month   = cal_month;
    s.day     = cal_day;
    s.weekday = cal_wday;
    s.hour    = cal_hour;
    s.minute  = cal_min;
    s.second  = cal_sec;
    return s;
  endfunction

  function automatic clock_cmd_t mk_cmd(int act, int delta, int y, int mo, int d,
                                        int h, int mi, int s, int ms);
    clock_cmd_t c;
    c.action          = 2'(act);
    c.delta_ms        = DELTA_W'(delta);
    c.set_year        = YEAR_W'(y);
    c.set_month       = MONTH_W'(mo);
    c.set_day         = DAY_W'(d);
    c.set_hour        = HOUR_W'(h);
    c.set_minute      = MIN_W'(mi);
    c.set_second      = SEC_W'(s);
    c.set_millisecond = MS_W'(ms);
    return c;
  endfunction

  function automatic stamp_t mk_stamp(int y, int mo, int d, int wd, int h, int mi, int s);
    stamp_t t;
    t.year    = YEAR_W'(y);
    t.month   = MONTH_W'(mo);
    t.day     = DAY_W'(d);
    t.weekday = WDAY_W'(wd);
    t.hour    = HOUR_W'(h);
    t.minute  = MIN_W'(mi);
    t.second  = SEC_W'(s);
    return t;
  endfunction

  task automatic add_row(input logic wr, input int rate, input clock_cmd_t c,
                         input logic typed, input stamp_t want);
    dir_row_t r;
    r.wr_rate = wr;
    r.rate    = MULT_W'(rate);
    r.cmd     = c;
    r.typed   = typed;
    r.want    = want;
    directed_rows.push_back(r);
  endtask

  function automatic string stamp_text(stamp_t s);
    return $sformatf("%0d-%0d-%0d wd %0d %0d:%0d:%0d",
                     s.year, s.month, s.day, s.weekday, s.hour, s.minute, s.second);
  endfunction

  // mostly ticks; set dates lean to month ends, leap and limit years; set times near midnight
  function automatic clock_cmd_t rand_cmd();
    clock_cmd_t  c;
    int unsigned pick;
    c.action          = ACT_TICK;
    c.delta_ms        = DELTA_W'($urandom_range(999));
    c.set_year        = YEAR_W'($urandom);
    c.set_month       = MONTH_W'($urandom);
    c.set_day         = DAY_W'($urandom);
    c.set_hour        = HOUR_W'($urandom);
    c.set_minute      = MIN_W'($urandom);
    c.set_second      = SEC_W'($urandom);
    c.set_millisecond = MS_W'($urandom);
    pick = $urandom_range(99);
    if (pick < 12) begin
      c.action = ACT_SET_DATE;
      case ($urandom_range(5))
        0: c.set_year = YEAR_LIMIT - YEAR_W'($urandom_range(1));
        1: begin
          case ($urandom_range(4))
            0:       c.set_year = YEAR_W'(0);
            1:       c.set_year = YEAR_W'(1900);
            2:       c.set_year = YEAR_W'(2000);
            3:       c.set_year = YEAR_W'(2100);
            default: c.set_year = YEAR_W'(2400);
          endcase
        end
        2: c.set_year = YEAR_W'(4 * $urandom_range(2499));
        3: c.set_year = YEAR_W'($urandom_range(9999));
        default: ;
      endcase
      if ($urandom_range(3) != 0) c.set_month = MONTH_W'($urandom_range(12, 1));
      if ($urandom_range(1) != 0) c.set_day = DAY_W'($urandom_range(31, 27));
    end else if (pick < 24) begin
      c.action = ACT_SET_TIME;
      if ($urandom_range(1) != 0) begin
        c.set_hour        = HOUR_W'($urandom_range(31, 23));
        c.set_minute      = MIN_W'($urandom_range(63, 59));
        c.set_second      = SEC_W'($urandom_range(63, 55));
        c.set_millisecond = MS_W'($urandom_range(1023, 900));
      end
    end else if (pick < 28) begin
      c.action = ACT_NONE;
    end
    return c;
  endfunction

  task automatic note_failure(input string msg);
    fail_count++;
    if (fail_count <= MAX_REPORTS) $display("%s", msg);
  endtask

  // send one item, then record what it should produce
  task automatic put_item(input clock_cmd_t c, input logic typed, input stamp_t want);
    stamp_t next_stamp;
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= c.action;
    s_axis_tdata  <= {4'd0, c.set_millisecond, c.set_second, c.set_minute, c.set_hour,
                      c.set_day, c.set_month, c.set_year, c.delta_ms};
    do @(posedge clk_i); while (!s_axis_tready);
    next_stamp = calendar_step(c);
    stamp_q.push_back(typed ? want : next_stamp);
  endtask

  // stop sending until every pending result is back
  task automatic hold_until_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (stamp_q.size() != 0);
  endtask

  task automatic write_rate(input logic [MULT_W-1:0] v);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    game_rate = v;
  endtask

  // receiver backpressure
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // result check against the oldest pending stamp
  always @(posedge clk_i) begin : result_check
    stamp_t got;
    stamp_t want;
    string  bad;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = stamp_t'(m_axis_tdata[$bits(stamp_t)-1:0]);
      if (stamp_q.size() == 0) begin
        note_failure($sformatf("unexpected result %s", stamp_text(got)));
      end else begin
        want = stamp_q.pop_front();
        bad  = "";
        if (got.year !== want.year) bad = {bad, " year"};
        if (got.month !== want.month) bad = {bad, " month"};
        if (got.day !== want.day) bad = {bad, " day"};
        if (got.weekday !== want.weekday) bad = {bad, " weekday"};
        if (got.hour !== want.hour) bad = {bad, " hour"};
        if (got.minute !== want.minute) bad = {bad, " minute"};
        if (got.second !== want.second) bad = {bad, " second"};
        if (bad != "") begin
          note_failure($sformatf("mismatch in%s: expected %s, got %s",
                                 bad, stamp_text(want), stamp_text(got)));
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned rate;
    calendar_reset();

    // directed: reset state, field extremes, clamps, leap rules, year cap, zero and big rates
    add_row(1'b1, 1, mk_cmd(ACT_NONE, 999, 9999, 12, 31, 23, 59, 59, 999),
            1'b1, mk_stamp(0, 1, 1, 6, 0, 0, 0));
    add_row(1'b0, 0, mk_cmd(ACT_TICK, 0, 0, 0, 0, 0, 0, 0, 0),
            1'b1, mk_stamp(0, 1, 1, 6, 0, 0, 0));
    add_row(1'b0, 0, mk_cmd(ACT_SET_DATE, 512, 16383, 15, 31, 0, 0, 0, 0),
            1'b1, mk_stamp(9999, 12, 31, 5, 0, 0, 0));
    add_row(1'b0, 0, mk_cmd(ACT_SET_TIME, 0, 0, 0, 0, 31, 63, 63, 1023),
            1'b1, mk_stamp(9999, 12, 31, 5, 23, 59, 59));
    add_row(1'b0, 0, mk_cmd(ACT_TICK, 1, 0, 0, 0, 0, 0, 0, 0),
            1'b1, mk_stamp(9999, 1, 1, 6, 0, 0, 0));
    add_row(1'b0, 0, mk_cmd(ACT_SET_DATE, 0, 0, 0, 0, 0, 0, 0, 0),
            1'b1, mk_stamp(0, 1, 1, 6, 0, 0, 0));
    add_row(1'b0, 0, mk_cmd(ACT_SET_DATE, 0, 0, 2, 31, 0, 0, 0, 0),
            1'b1, mk_stamp(0, 2, 29, 2, 0, 0, 0));
    add_row(1'b0, 0, mk_cmd(ACT_TICK, 999, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0);
    add_row(1'b1, 0, mk_cmd(ACT_TICK, 999, 0, 0, 0, 0, 0, 0, 0),
            1'b1, mk_stamp(0, 2, 29, 2, 0, 0, 0));
    add_row(1'b1, 86400, mk_cmd(ACT_TICK, 999, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0);
    add_row(1'b0, 0, mk_cmd(ACT_TICK, 999, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0);
    add_row(1'b0, 0, mk_cmd(ACT_SET_DATE, 3, 1900, 2, 29, 0, 0, 0, 0), 1'b0, '0);
    add_row(1'b0, 0, mk_cmd(ACT_SET_DATE, 3, 2000, 2, 30, 0, 0, 0, 0), 1'b0, '0);
    add_row(1'b0, 0, mk_cmd(ACT_SET_TIME, 3, 0, 0, 0, 23, 59, 59, 999), 1'b0, '0);
    add_row(1'b0, 0, mk_cmd(ACT_TICK, 1, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0);
    add_row(1'b1, 131071, mk_cmd(ACT_SET_DATE, 0, 2023, 12, 31, 0, 0, 0, 0), 1'b0, '0);
    add_row(1'b0, 0, mk_cmd(ACT_SET_TIME, 0, 0, 0, 0, 23, 59, 59, 999), 1'b0, '0);
    add_row(1'b0, 0, mk_cmd(ACT_TICK, 999, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0);
    add_row(1'b0, 0, mk_cmd(ACT_SET_DATE, 0, 9999, 12, 30, 0, 0, 0, 0), 1'b0, '0);
    add_row(1'b0, 0, mk_cmd(ACT_SET_TIME, 0, 0, 0, 0, 23, 59, 59, 999), 1'b0, '0);
    add_row(1'b0, 0, mk_cmd(ACT_TICK, 999, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0);
    add_row(1'b0, 0, mk_cmd(ACT_SET_DATE, 0, 2100, 2, 29, 0, 0, 0, 0), 1'b0, '0);
    add_row(1'b0, 0, mk_cmd(ACT_SET_TIME, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0);
    add_row(1'b0, 0, mk_cmd(ACT_NONE, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0);

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < directed_rows.size(); i++) begin
      if (directed_rows[i].wr_rate) begin
        hold_until_drained();
        write_rate(directed_rows[i].rate);
      end
      put_item(directed_rows[i].cmd, directed_rows[i].typed, directed_rows[i].want);
    end

    // random phases, each setting a rate and an idle pattern
    for (int p = 0; p < NUM_PHASES; p++) begin
      hold_until_drained();
      case (p)
        0, 4, 7: rate = 86400;
        1:       rate = 1;
        2:       rate = 60000;
        5:       rate = 1000;
        default: rate = $urandom_range(86400, 1);
      endcase
      write_rate(MULT_W'(rate));
      case (p % 4)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 61; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 61; end
        default: begin send_idle_pct = 26; recv_stall_pct = 26; end
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (p == 1 && n == PHASE_ITEMS / 2) hold_until_drained();
        put_item(rand_cmd(), 1'b0, '0);
      end
    end

    hold_until_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
